>>> sv/dct_pkg.sv
package dct_pkg;

  localparam int ID_W      = 16;
  localparam int WGT_W     = 32;
  localparam int HIT_W     = 16;
  localparam int MAG_W     = 25;
  localparam int SHARE_W   = 15;
  localparam int DIST_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_BITS = 8;
  localparam int PCT_W     = 7;
  // quotient bits kept by the divider, two above the share so overflow shows
  localparam int QUOT_W    = SHARE_W + 2;

  localparam logic [WGT_W-1:0]   WGT_MAX   = '1;
  localparam logic [HIT_W-1:0]   HIT_MAX   = '1;
  localparam logic [SHARE_W-1:0] SHARE_MAX = '1;
  localparam logic [PCT_W-1:0]   PERCENT   = 7'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANK_BY_COUNT     = 2'd0,
    CFG_INCLUDE_UNTRACKED = 2'd1,
    CFG_NORM_MODE         = 2'd2
  } dct_cfg_idx_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [WGT_W-1:0] weight;
    logic [HIT_W-1:0] hits;
  } dct_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_EVAL_RD,
    ST_EVAL_ACC,
    ST_FOLD,
    ST_PREP,
    ST_DIV_GO,
    ST_DIV_WAIT
  } dct_state_t;

endpackage

>>> sv/dct_ram.sv
module dct_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/dct_div.sv
module dct_div import dct_pkg::*; #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 37
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [NUM_W-1:0]   num,
  input  logic [DEN_W-1:0]   den,
  output logic               done,
  output logic [SHARE_W-1:0] quot
);

  // rounded quotient (2*num + den) / (2*den), restoring, one bit a cycle
  localparam int DVD_W  = ((NUM_W + 1 > DEN_W) ? NUM_W + 1 : DEN_W) + 1;
  localparam int DSH_W  = DEN_W + QUOT_W;
  localparam int CMP_W  = (DVD_W > DSH_W) ? DVD_W : DSH_W;
  localparam int STEP_W = $clog2(QUOT_W);

  logic              run_r;
  logic              done_r;
  logic              zero_r;
  logic [STEP_W-1:0] step_r;
  logic [DVD_W-1:0]  rem_r;
  logic [DSH_W-1:0]  dsh_r;
  logic [QUOT_W-1:0] q_r;

  logic [CMP_W-1:0] rem_ext;
  logic [CMP_W-1:0] dsh_ext;
  logic [CMP_W-1:0] diff;
  logic             ge;

  assign rem_ext = CMP_W'(rem_r);
  assign dsh_ext = CMP_W'(dsh_r);
  assign ge      = rem_ext >= dsh_ext;
  assign diff    = rem_ext - dsh_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && step_r == '0) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= DVD_W'({num, 1'b0}) + DVD_W'(den);
      dsh_r  <= DSH_W'({den, 1'b0}) << (QUOT_W - 1);
      q_r    <= '0;
      step_r <= STEP_W'(QUOT_W - 1);
      zero_r <= den == '0;
    end else if (run_r) begin
      if (ge) begin
        rem_r <= diff[DVD_W-1:0];
      end
      dsh_r  <= dsh_r >> 1;
      q_r    <= {q_r[QUOT_W-2:0], ge};
      step_r <= step_r - STEP_W'(1);
    end
  end

  assign done = done_r;
  // a top bit set means the true quotient is at least the saturation limit
  assign quot = zero_r                     ? '0 :
                (|q_r[QUOT_W-1:SHARE_W])   ? SHARE_MAX :
                                             q_r[SHARE_W-1:0];

endmodule

>>> sv/dominant_contributor_tally.sv
// Tallies items (track id, signed weight) into a table of TABLE_ENTRIES
// entries held in a single-port-write, registered-read RAM, and on an item
// with in_last set reports the dominant nonzero id, its rounded share and
// the number of entries used, then empties the table. busy is high from the
// accepting edge until the item is fully processed; start is ignored
// meanwhile. An item scans the table one entry at a time (RAM read, then
// compare and write back) until an entry in use matches; when none of
// the entries in use matches, a new entry is written if the table has
// room. An item marked last then rescans the whole table, folds, scales
// and starts the bit-serial divider, then waits for its result.
// The result appears on out_valid for exactly one cycle and must be taken
// then; there is no way to stall it. Configuration writes are only
// meaningful while busy is low and no result is pending.
module dominant_contributor_tally import dct_pkg::*; #(
  parameter int TABLE_ENTRIES = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [0:0]           cfg_wdata,
  input  logic                 start,
  output logic                 busy,
  input  logic [ID_W-1:0]      in_track_id,
  input  logic signed [MAG_W-1:0] in_weight,
  input  logic                 in_last,
  output logic                 out_valid,
  output logic [ID_W-1:0]      out_winner_id,
  output logic [SHARE_W-1:0]   out_share,
  output logic [DIST_W-1:0]    out_distinct_tracks
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int TOT_W  = WGT_W + $clog2(TABLE_ENTRIES);
  localparam int HSUM_W = HIT_W + $clog2(TABLE_ENTRIES);
  localparam int BEST_W = WGT_W + 1;
  localparam int NUM_W  = BEST_W + PCT_W;
  localparam int ENT_W  = $bits(dct_entry_t);

  dct_state_t state_r, state_nxt;

  logic             rank_by_count_r;
  logic             include_untracked_r;
  logic             norm_mode_r;

  logic [CNT_W-1:0] used_r;
  logic [CNT_W-1:0] scan_r;
  logic [ID_W-1:0]  id_r;
  logic [MAG_W-1:0] mag_r;
  logic             last_r;

  logic [BEST_W-1:0] best_r;
  logic [TOT_W-1:0]  total_r;
  logic [HSUM_W-1:0] hsum_r;
  logic [WGT_W-1:0]  zero_v_r;
  logic [HIT_W-1:0]  zero_h_r;
  logic [ID_W-1:0]   win_r;
  logic [NUM_W-1:0]  num_r;
  logic [TOT_W-1:0]  den_r;

  logic               out_valid_r;
  logic [ID_W-1:0]    out_winner_id_r;
  logic [SHARE_W-1:0] out_share_r;
  logic [DIST_W-1:0]  out_distinct_r;

  logic               accept;
  logic               scan_end;
  logic               room;
  logic               hit;
  logic [MAG_W-1:0]   raw;
  logic [MAG_W-1:0]   mag;
  dct_entry_t         rd_ent;
  dct_entry_t         upd_ent;
  dct_entry_t         new_ent;
  logic [WGT_W:0]     wsum;
  logic [WGT_W-1:0]   v;
  logic [WGT_W-1:0]   zero_v_sel;
  logic [HIT_W-1:0]   zero_h_sel;
  logic               pct_mode;
  logic [CNT_W+DIST_W-1:0] used_ext;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENT_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENT_W-1:0]   ram_rdata;
  logic               div_start;
  logic               div_done;
  logic [SHARE_W-1:0] div_quot;

  assign busy     = state_r != ST_IDLE;
  assign accept   = start && !busy;
  assign scan_end = scan_r == used_r;
  assign room     = used_r < CNT_W'(TABLE_ENTRIES);

  assign raw = $unsigned(in_weight);
  assign mag = raw[MAG_W-1] ? (~raw + MAG_W'(1)) : raw;

  assign rd_ent = dct_entry_t'(ram_rdata);
  assign hit    = rd_ent.id == id_r;

  // saturating accumulate of a matching entry
  assign wsum           = {1'b0, rd_ent.weight} + (WGT_W + 1)'(mag_r);
  assign upd_ent.id     = rd_ent.id;
  assign upd_ent.weight = wsum[WGT_W] ? WGT_MAX : wsum[WGT_W-1:0];
  assign upd_ent.hits   = (rd_ent.hits == HIT_MAX) ? HIT_MAX : rd_ent.hits + HIT_W'(1);

  assign new_ent.id     = id_r;
  assign new_ent.weight = WGT_W'(mag_r);
  assign new_ent.hits   = HIT_W'(1);

  assign v          = rank_by_count_r ? WGT_W'(rd_ent.hits) : rd_ent.weight;
  assign zero_v_sel = include_untracked_r ? zero_v_r : '0;
  assign zero_h_sel = include_untracked_r ? zero_h_r : '0;
  assign pct_mode   = rank_by_count_r || !norm_mode_r;
  assign used_ext   = (CNT_W + DIST_W)'(used_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        if (scan_end) begin
          state_nxt = last_r ? ST_EVAL_RD : ST_IDLE;
        end else begin
          state_nxt = ST_SRCH_CMP;
        end
      end
      ST_SRCH_CMP: begin
        if (hit) begin
          state_nxt = last_r ? ST_EVAL_RD : ST_IDLE;
        end else begin
          state_nxt = ST_SRCH_RD;
        end
      end
      ST_EVAL_RD:  state_nxt = scan_end ? ST_FOLD : ST_EVAL_ACC;
      ST_EVAL_ACC: state_nxt = ST_EVAL_RD;
      ST_FOLD:     state_nxt = ST_PREP;
      ST_PREP:     state_nxt = ST_DIV_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // ram and divider controls
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan_r[IDX_W-1:0];
    ram_wdata = upd_ent;
    ram_raddr = scan_r[IDX_W-1:0];
    div_start = 1'b0;
    unique case (state_r)
      ST_SRCH_RD: begin
        if (scan_end && room) begin
          ram_we    = 1'b1;
          ram_waddr = used_r[IDX_W-1:0];
          ram_wdata = new_ent;
        end
      end
      ST_SRCH_CMP: begin
        ram_we = hit;
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r             <= ST_IDLE;
      rank_by_count_r     <= 1'b0;
      include_untracked_r <= 1'b0;
      norm_mode_r         <= 1'b1;
      used_r              <= '0;
      out_valid_r         <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_idx == CFG_RANK_BY_COUNT) begin
          rank_by_count_r <= cfg_wdata[0];
        end
        if (cfg_idx == CFG_INCLUDE_UNTRACKED) begin
          include_untracked_r <= cfg_wdata[0];
        end
        if (cfg_idx == CFG_NORM_MODE) begin
          norm_mode_r <= cfg_wdata[0];
        end
      end
      if (state_r == ST_SRCH_RD && scan_end && room) begin
        used_r <= used_r + CNT_W'(1);
      end
      if (state_r == ST_DIV_WAIT && div_done) begin
        out_valid_r <= 1'b1;
        used_r      <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      id_r   <= in_track_id;
      mag_r  <= mag;
      last_r <= in_last;
      scan_r <= '0;
    end
    unique case (state_r)
      ST_SRCH_RD: begin
        if (scan_end) begin
          scan_r <= '0;
        end
      end
      ST_SRCH_CMP: begin
        scan_r <= hit ? '0 : scan_r + CNT_W'(1);
      end
      ST_EVAL_ACC: begin
        scan_r <= scan_r + CNT_W'(1);
        if (rd_ent.id == '0) begin
          zero_v_r <= v;
          zero_h_r <= rd_ent.hits;
        end else begin
          hsum_r  <= hsum_r + HSUM_W'(rd_ent.hits);
          total_r <= total_r + TOT_W'(v);
          // ties go to the later entry
          if (BEST_W'(v) >= best_r) begin
            best_r <= BEST_W'(v);
            win_r  <= rd_ent.id;
          end
        end
      end
      ST_FOLD: begin
        best_r  <= best_r + BEST_W'(zero_v_sel);
        total_r <= total_r + TOT_W'(zero_v_sel);
        hsum_r  <= hsum_r + HSUM_W'(zero_h_sel);
      end
      ST_PREP: begin
        if (pct_mode) begin
          num_r <= NUM_W'(best_r) * NUM_W'(PERCENT);
          den_r <= total_r;
        end else begin
          num_r <= NUM_W'(best_r);
          den_r <= TOT_W'({hsum_r, {FRAC_BITS{1'b0}}});
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          out_winner_id_r <= win_r;
          out_share_r     <= div_quot;
          out_distinct_r  <= used_ext[DIST_W-1:0];
        end
      end
      default: begin
      end
    endcase
    // accumulators start clean on the way into the evaluation scan
    if (state_nxt == ST_EVAL_RD && state_r != ST_EVAL_ACC) begin
      best_r   <= '0;
      total_r  <= '0;
      hsum_r   <= '0;
      zero_v_r <= '0;
      zero_h_r <= '0;
      win_r    <= '0;
    end
  end

  dct_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dct_div #(
    .NUM_W (NUM_W),
    .DEN_W (TOT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign out_valid           = out_valid_r;
  assign out_winner_id       = out_winner_id_r;
  assign out_share           = out_share_r;
  assign out_distinct_tracks = out_distinct_r;

endmodule
